// ===== rtl/prrs_pkg.sv =====
// Shared types and constants for the priority round-robin scheduler.
package prrs_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int RANGE_W     = 11;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [2:0] STAT_DYING    = 3'd1;
  localparam logic [2:0] STAT_RUNNABLE = 3'd2;
  localparam logic [2:0] STAT_RUNNING  = 3'd3;

  localparam logic REQ_UPDATE = 1'b0;

  localparam logic [1:0] CFG_SCHED_MODE     = 2'd0;
  localparam logic [1:0] CFG_PRIORITY_FLOOR = 2'd1;
  localparam logic [1:0] CFG_AGING_PERIOD   = 2'd2;

  localparam logic       MODE_RST   = 1'b1;
  localparam logic [3:0] FLOOR_RST  = 4'd10;
  localparam logic [3:0] PERIOD_RST = 4'd5;
  localparam logic [3:0] PRIO_MAX   = 4'd15;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] prio;
    logic [3:0] phase;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic wr_status;
    logic wr_prio;
    logic wr_phase;
    logic clr_prio;
  } cell_ctrl_t;

  typedef struct packed {
    logic       grant_valid;
    logic [5:0] grant_index;
    logic       kept_current;
    logic       cpu_halt;
    logic       system_idle;
    logic       priorities_reset;
  } res_t;

endpackage

// ===== rtl/prrs_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
interface prrs_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] entry_index;
  logic [2:0] entry_status;
  logic [3:0] entry_priority;
  logic       current_valid;
  logic [5:0] current_index;

  modport source (output valid, req_type, entry_index, entry_status, entry_priority,
                  current_valid, current_index, input ready);
  modport sink (input valid, req_type, entry_index, entry_status, entry_priority,
                current_valid, current_index, output ready);
endinterface

interface prrs_res_if;
  logic       valid;
  logic       ready;
  logic       grant_valid;
  logic [5:0] grant_index;
  logic       kept_current;
  logic       cpu_halt;
  logic       system_idle;
  logic       priorities_reset;

  modport source (output valid, grant_valid, grant_index, kept_current, cpu_halt,
                  system_idle, priorities_reset, input ready);
  modport sink (input valid, grant_valid, grant_index, kept_current, cpu_halt,
                system_idle, priorities_reset, output ready);
endinterface

interface prrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/prrs_cell.sv =====
// One table entry of the rotating ring: status, priority and run phase.
module prrs_cell
  import prrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     shift_i,
  input  entry_t     wr_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = shift_i;
    end else begin
      if (ctrl_i.wr_status) entry_d.status = wr_i.status;
      if (ctrl_i.wr_prio)   entry_d.prio   = wr_i.prio;
      if (ctrl_i.wr_phase)  entry_d.phase  = wr_i.phase;
      if (ctrl_i.clr_prio)  entry_d.prio   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/priority_round_robin_scheduler_top.sv =====
// Scheduler top level: ring of entry cells, scan unit, control and output register.
// Update transaction: after acceptance the result is loaded into the output register in PUSH.
// Schedule transaction: the ring rotates one entry per cycle past the scan unit at its head
// during SCAN, then COMMIT writes back and PUSH loads the result. One transaction in flight
// at a time; a held-off result stalls PUSH, and the next is accepted only after the load.
// Reset (async, active low) clears all tables and loads the register defaults; no clear pass.
module priority_round_robin_scheduler_top
  import prrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  prrs_req_if.sink   req_i,
  prrs_res_if.source res_o,
  prrs_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_PUSH   = 4'b1000
  } state_e;

  function automatic logic [3:0] next_phase(logic [3:0] phase, logic [3:0] period);
    logic [3:0] eff;
    logic [4:0] nxt;
    eff = (period == '0) ? 4'd1 : period;
    nxt = {1'b0, phase} + 5'd1;
    return (nxt >= {1'b0, eff}) ? 4'd0 : nxt[3:0];
  endfunction

  state_e     state_q, state_d;
  logic       mode_q;
  logic [3:0] floor_q, period_q;

  idx_t       t_q, d_q, best_d_q, best_idx_q, cidx_q;
  logic       have_q, cvalid_q, busy_q;
  logic [3:0] best_prio_q, best_phase_q, cur_phase_q;
  logic [2:0] cur_stat_q;
  res_t       pend_q, res_q;
  logic       res_valid_q;

  entry_t     cells [NUM_ENTRIES];
  cell_ctrl_t ctrl  [NUM_ENTRIES];

  logic       req_acc, upd, upd_in_range, cvalid_in, scanning, last;
  idx_t       start, wr_idx;
  entry_t     head, wr_data;
  logic       wr_status, wr_prio, wr_phase, clr_prio;
  logic       cand, better, live, kept, preset, load;
  logic [3:0] aged_prio, new_phase;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign upd         = (req_i.req_type == REQ_UPDATE);
  assign upd_in_range = (RANGE_W'(req_i.entry_index) < RANGE_W'(NUM_ENTRIES));
  assign cvalid_in   = req_i.current_valid &&
                       (RANGE_W'(req_i.current_index) < RANGE_W'(NUM_ENTRIES));
  assign start       = cvalid_in ? IDX_W'(req_i.current_index) : '0;
  assign scanning    = (state_q == S_SCAN);
  assign last        = (t_q == IDX_W'(NUM_ENTRIES - 1));
  assign head        = cells[0];

  // Scan evaluation of the entry at the head of the ring
  assign cand   = (head.status == STAT_RUNNABLE) && (!mode_q || head.prio < floor_q);
  assign better = !have_q ||
                  (mode_q ? ((head.prio < best_prio_q) ||
                             (head.prio == best_prio_q && d_q < best_d_q))
                          : (d_q < best_d_q));
  assign live   = head.status inside {STAT_DYING, STAT_RUNNABLE, STAT_RUNNING};

  // Commit
  assign kept      = !have_q && cvalid_q && (cur_stat_q == STAT_RUNNING);
  assign aged_prio = (mode_q && best_phase_q == '0 && best_prio_q != PRIO_MAX) ?
                     best_prio_q + 4'd1 : best_prio_q;
  assign preset    = have_q && mode_q && (aged_prio == floor_q);
  assign new_phase = next_phase(have_q ? best_phase_q : cur_phase_q, period_q);

  always_comb begin
    wr_idx    = '0;
    wr_data   = '0;
    wr_status = 1'b0;
    wr_prio   = 1'b0;
    wr_phase  = 1'b0;
    clr_prio  = 1'b0;
    if (state_q == S_IDLE && req_acc && upd && upd_in_range) begin
      wr_idx         = IDX_W'(req_i.entry_index);
      wr_data.status = req_i.entry_status;
      wr_data.prio   = req_i.entry_priority;
      wr_status      = 1'b1;
      wr_prio        = 1'b1;
    end else if (state_q == S_COMMIT) begin
      wr_idx        = have_q ? best_idx_q : cidx_q;
      wr_data.prio  = aged_prio;
      wr_data.phase = new_phase;
      wr_prio       = have_q;
      wr_phase      = have_q || kept;
      clr_prio      = preset;
    end
  end

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_ring
    localparam int NXT = (k + 1) % NUM_ENTRIES;
    logic sel;
    assign sel = (wr_idx == IDX_W'(k));
    assign ctrl[k] = '{shift:     scanning,
                       wr_status: wr_status && sel,
                       wr_prio:   wr_prio && sel,
                       wr_phase:  wr_phase && sel,
                       clr_prio:  clr_prio};
    prrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .shift_i (cells[NXT]),
      .wr_i    (wr_data),
      .entry_o (cells[k])
    );
  end

  assign load = (state_q == S_PUSH) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_acc) state_d = upd ? S_PUSH : S_SCAN;
      S_SCAN:   if (last) state_d = S_COMMIT;
      S_COMMIT: state_d = S_PUSH;
      S_PUSH:   if (load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_RST;
      floor_q     <= FLOOR_RST;
      period_q    <= PERIOD_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_SCHED_MODE:     mode_q   <= cfg_i.data[0];
          CFG_PRIORITY_FLOOR: floor_q  <= cfg_i.data;
          CFG_AGING_PERIOD:   period_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cvalid_q   <= cvalid_in;
      cidx_q     <= start;
      t_q        <= '0;
      d_q        <= IDX_W'(NUM_ENTRIES - 1) - start;
      have_q     <= 1'b0;
      busy_q     <= 1'b0;
      cur_stat_q <= '0;
      cur_phase_q <= '0;
      if (upd) pend_q <= '0;
    end
    if (scanning) begin
      t_q <= t_q + 1'b1;
      d_q <= (d_q == IDX_W'(NUM_ENTRIES - 1)) ? '0 : d_q + 1'b1;
      if (live) busy_q <= 1'b1;
      if (cand && better) begin
        have_q       <= 1'b1;
        best_idx_q   <= t_q;
        best_d_q     <= d_q;
        best_prio_q  <= head.prio;
        best_phase_q <= head.phase;
      end
      if (t_q == cidx_q) begin
        cur_stat_q  <= head.status;
        cur_phase_q <= head.phase;
      end
    end
    if (state_q == S_COMMIT) begin
      pend_q.grant_valid      <= have_q || kept;
      pend_q.grant_index      <= (have_q || kept) ? 6'(wr_idx) : 6'd0;
      pend_q.kept_current     <= kept;
      pend_q.cpu_halt         <= !(have_q || kept);
      pend_q.system_idle      <= !busy_q;
      pend_q.priorities_reset <= preset;
    end
    if (load) res_q <= pend_q;
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.grant_valid      = res_q.grant_valid;
  assign res_o.grant_index      = res_q.grant_index;
  assign res_o.kept_current     = res_q.kept_current;
  assign res_o.cpu_halt         = res_q.cpu_halt;
  assign res_o.system_idle      = res_q.system_idle;
  assign res_o.priorities_reset = res_q.priorities_reset;

endmodule

// ===== dv/tb_priority_round_robin_scheduler_top.sv =====
`timescale 1ns / 100ps
// Testbench for the priority round-robin scheduler: stimulus, grant prediction and checking.

typedef struct packed {
  logic       req_type;
  logic [5:0] entry_index;
  logic [2:0] entry_status;
  logic [3:0] entry_priority;
  logic       current_valid;
  logic [5:0] current_index;
} sched_req_t;

class scheduler_scoreboard;
  logic [2:0] status_tbl [prrs_pkg::NUM_ENTRIES];
  logic [3:0] prio_tbl [prrs_pkg::NUM_ENTRIES];
  logic [3:0] phase_tbl [prrs_pkg::NUM_ENTRIES];
  logic       prio_mode;
  logic [3:0] floor_lvl;
  logic [3:0] age_period;
  prrs_pkg::res_t awaited_grants [$];
  int errors;

  function new();
    foreach (status_tbl[e]) begin
      status_tbl[e] = '0;
      prio_tbl[e]   = '0;
      phase_tbl[e]  = '0;
    end
    prio_mode  = prrs_pkg::MODE_RST;
    floor_lvl  = prrs_pkg::FLOOR_RST;
    age_period = prrs_pkg::PERIOD_RST;
    errors     = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [3:0] data);
    case (idx)
      prrs_pkg::CFG_SCHED_MODE:     prio_mode  = data[0];
      prrs_pkg::CFG_PRIORITY_FLOOR: floor_lvl  = data;
      prrs_pkg::CFG_AGING_PERIOD:   age_period = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited_grants.size();
  endfunction

  // Works out the grant for one accepted transaction and queues it.
  function void note_request(sched_req_t r);
    prrs_pkg::res_t want;
    int base, j, best, pick, span, nxt;
    bit found, kept, cleared, idle;
    want = '0;
    if (r.req_type == prrs_pkg::REQ_UPDATE) begin
      status_tbl[r.entry_index] = r.entry_status;
      prio_tbl[r.entry_index]   = r.entry_priority;
    end else begin
      found   = 1'b0;
      kept    = 1'b0;
      cleared = 1'b0;
      idle    = 1'b1;
      pick    = 0;
      base    = r.current_valid ? int'(r.current_index) : 0;
      best    = int'(floor_lvl);
      for (int i = 1; i <= prrs_pkg::NUM_ENTRIES; i++) begin
        j = (base + i) % prrs_pkg::NUM_ENTRIES;
        if (status_tbl[j] == prrs_pkg::STAT_RUNNABLE) begin
          if (!prio_mode) begin
            if (!found) begin
              found = 1'b1;
              pick  = j;
            end
          end else if (int'(prio_tbl[j]) < best) begin
            found = 1'b1;
            pick  = j;
            best  = int'(prio_tbl[j]);
          end
        end
      end
      if (found) begin
        if (prio_mode) begin
          if (phase_tbl[pick] == 4'd0 && prio_tbl[pick] != prrs_pkg::PRIO_MAX)
            prio_tbl[pick] = prio_tbl[pick] + 4'd1;
          if (prio_tbl[pick] == floor_lvl) begin
            foreach (prio_tbl[e]) prio_tbl[e] = '0;
            cleared = 1'b1;
          end
        end
      end else if (r.current_valid && status_tbl[r.current_index] == prrs_pkg::STAT_RUNNING) begin
        found = 1'b1;
        kept  = 1'b1;
        pick  = int'(r.current_index);
      end
      if (found) begin
        span = (age_period == 4'd0) ? 1 : int'(age_period);
        nxt  = int'(phase_tbl[pick]) + 1;
        phase_tbl[pick] = (nxt >= span) ? 4'd0 : 4'(nxt);
      end
      foreach (status_tbl[e])
        if (status_tbl[e] inside {prrs_pkg::STAT_RUNNABLE, prrs_pkg::STAT_RUNNING,
                                  prrs_pkg::STAT_DYING})
          idle = 1'b0;
      want.grant_valid      = found;
      want.grant_index      = found ? 6'(pick) : 6'd0;
      want.kept_current     = kept;
      want.cpu_halt         = !found;
      want.system_idle      = idle;
      want.priorities_reset = cleared;
    end
    awaited_grants.push_back(want);
  endfunction

  function void check_grant(prrs_pkg::res_t got);
    prrs_pkg::res_t want;
    if (awaited_grants.size() == 0) begin
      $error("result with no transaction outstanding");
      errors++;
      return;
    end
    want = awaited_grants.pop_front();
    if (got.grant_valid !== want.grant_valid) begin
      $error("grant_valid: expected %0d, got %0d", want.grant_valid, got.grant_valid);
      errors++;
    end
    if (got.grant_index !== want.grant_index) begin
      $error("grant_index: expected %0d, got %0d", want.grant_index, got.grant_index);
      errors++;
    end
    if (got.kept_current !== want.kept_current) begin
      $error("kept_current: expected %0d, got %0d", want.kept_current, got.kept_current);
      errors++;
    end
    if (got.cpu_halt !== want.cpu_halt) begin
      $error("cpu_halt: expected %0d, got %0d", want.cpu_halt, got.cpu_halt);
      errors++;
    end
    if (got.system_idle !== want.system_idle) begin
      $error("system_idle: expected %0d, got %0d", want.system_idle, got.system_idle);
      errors++;
    end
    if (got.priorities_reset !== want.priorities_reset) begin
      $error("priorities_reset: expected %0d, got %0d", want.priorities_reset,
             got.priorities_reset);
      errors++;
    end
  endfunction
endclass

module tb_priority_round_robin_scheduler_top
  import prrs_pkg::*;
();

  localparam int         CYCLE_LIMIT  = 1_500_000;
  localparam int         HOLD_AT      = 100;
  localparam int         HOLD_CYCLES  = 500;
  localparam logic       REQ_SCHEDULE = 1'b1;
  localparam logic [1:0] CFG_SPARE    = 2'd3;
  localparam logic [2:0] STAT_FREE    = 3'd0;
  localparam logic [2:0] STAT_BLOCKED = 3'd4;
  localparam logic [2:0] STAT_ODD_LO  = 3'd5;
  localparam logic [2:0] STAT_ODD_HI  = 3'd7;

  logic clk_i;
  logic rst_ni;

  prrs_req_if req_if();
  prrs_res_if res_if();
  prrs_cfg_if cfg_if();

  priority_round_robin_scheduler_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  scheduler_scoreboard sb;
  int  cycle_count;
  int  results_seen;
  int  stall_left;
  bit  quiet;
  res_t sampled;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99, 0);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Result side: random back-pressure plus one long hold-off.
  always begin
    @(negedge clk_i);
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
    end
    @(posedge clk_i);
    if (rst_ni && res_if.valid && res_if.ready) begin
      sampled = {res_if.grant_valid, res_if.grant_index, res_if.kept_current,
                 res_if.cpu_halt, res_if.system_idle, res_if.priorities_reset};
      sb.check_grant(sampled);
      results_seen++;
      if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
      else stall_left = quiet ? 0 : gap_len();
    end
  end

  function automatic logic [5:0] pick_index(int win);
    if ($urandom_range(99, 0) < 85) return 6'($urandom_range(win - 1, 0));
    return 6'($urandom_range(63, 0));
  endfunction

  function automatic logic [2:0] pick_status();
    int p;
    p = $urandom_range(99, 0);
    if (p < 35) return STAT_RUNNABLE;
    if (p < 55) return STAT_RUNNING;
    if (p < 65) return STAT_DYING;
    if (p < 77) return STAT_FREE;
    if (p < 89) return STAT_BLOCKED;
    return 3'($urandom_range(STAT_ODD_HI, STAT_ODD_LO));
  endfunction

  function automatic logic [3:0] pick_prio();
    if ($urandom_range(1, 0) == 1) return 4'($urandom_range(3, 0));
    return 4'($urandom_range(15, 0));
  endfunction

  task automatic send_item(sched_req_t r);
    @(negedge clk_i);
    req_if.valid          <= 1'b1;
    req_if.req_type       <= r.req_type;
    req_if.entry_index    <= r.entry_index;
    req_if.entry_status   <= r.entry_status;
    req_if.entry_priority <= r.entry_priority;
    req_if.current_valid  <= r.current_valid;
    req_if.current_index  <= r.current_index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic pause_tx(int n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  task automatic send_update(logic [5:0] idx, logic [2:0] st, logic [3:0] pr);
    sched_req_t r;
    r.req_type       = REQ_UPDATE;
    r.entry_index    = idx;
    r.entry_status   = st;
    r.entry_priority = pr;
    r.current_valid  = 1'($urandom_range(1, 0));
    r.current_index  = 6'($urandom_range(63, 0));
    send_item(r);
  endtask

  task automatic send_sched(logic cv, logic [5:0] ci);
    sched_req_t r;
    r.req_type       = REQ_SCHEDULE;
    r.entry_index    = 6'($urandom_range(63, 0));
    r.entry_status   = 3'($urandom_range(7, 0));
    r.entry_priority = 4'($urandom_range(15, 0));
    r.current_valid  = cv;
    r.current_index  = ci;
    send_item(r);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Reconfigure once drained, then a stretch of random transactions, draining again halfway.
  task automatic run_phase(logic mode_v, logic [3:0] floor_v, logic [3:0] period_v,
                           int count, int win, bit calm);
    logic [3:0] mode_data;
    pause_tx(1);
    wait_drained();
    repeat (8) @(posedge clk_i);
    mode_data    = 4'($urandom_range(15, 0));
    mode_data[0] = mode_v;
    write_reg(CFG_SCHED_MODE, mode_data);
    write_reg(CFG_PRIORITY_FLOOR, floor_v);
    write_reg(CFG_AGING_PERIOD, period_v);
    quiet = calm;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) begin
        pause_tx(1);
        wait_drained();
      end
      if ($urandom_range(99, 0) < 50)
        send_update(pick_index(win), pick_status(), pick_prio());
      else
        send_sched($urandom_range(99, 0) < 80, pick_index(win));
      if (!quiet) pause_tx(gap_len());
    end
  endtask

  initial begin
    sb                    = new();
    cycle_count           = 0;
    results_seen          = 0;
    stall_left            = 0;
    quiet                 = 1'b0;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_UPDATE;
    req_if.entry_index    = '0;
    req_if.entry_status   = '0;
    req_if.entry_priority = '0;
    req_if.current_valid  = 1'b0;
    req_if.current_index  = '0;
    res_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_SCHED_MODE;
    cfg_if.data           = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset configuration: priority mode, floor 10, period 5
    send_sched(1'b0, 6'd0);
    send_update(6'd0, STAT_RUNNING, 4'd15);
    send_sched(1'b1, 6'd0);
    send_update(6'd63, STAT_RUNNABLE, 4'd0);
    send_update(6'd1, STAT_RUNNABLE, 4'd9);
    send_sched(1'b1, 6'd63);
    send_update(6'd5, STAT_ODD_HI, 4'd0);
    send_update(6'd6, STAT_BLOCKED, 4'd0);
    send_update(6'd7, STAT_DYING, 4'd0);
    send_sched(1'b0, 6'd63);
    send_update(6'd2, STAT_RUNNABLE, 4'd9);
    send_sched(1'b1, 6'd1);
    send_update(6'd63, STAT_BLOCKED, 4'd15);
    send_sched(1'b1, 6'd0);
    send_sched(1'b1, 6'd1);
    send_update(6'd1, STAT_FREE, 4'd0);
    send_update(6'd2, STAT_FREE, 4'd0);
    send_sched(1'b1, 6'd7);
    send_update(6'd0, 3'd6, 4'd3);
    send_update(6'd7, STAT_FREE, 4'd15);
    send_sched(1'b1, 6'd0);
    send_update(6'd63, STAT_RUNNABLE, 4'd15);
    send_sched(1'b0, 6'd0);
    send_sched(1'b1, 6'd63);

    run_phase(1'b0, 4'd15, 4'd1,  300, 16, 1'b0);
    run_phase(1'b1, 4'd1,  4'd1,  280, 8,  1'b1);
    run_phase(1'b1, 4'd15, 4'd15, 280, 64, 1'b0);
    run_phase(1'b1, 4'd3,  4'd2,  300, 8,  1'b0);
    pause_tx(1);
    wait_drained();
    write_reg(CFG_SPARE, 4'($urandom_range(15, 0)));
    run_phase(1'b1, 4'd0,  4'd0,  150, 16, 1'b0);
    run_phase(1'b0, 4'd10, 4'd15, 250, 64, 1'b1);
    run_phase(1'b1, 4'd10, 4'd5,  320, 12, 1'b0);

    pause_tx(1);
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
